@@ hdl/integer_string_parser_defines.svh @@
// assertion macros for the port-level checker file
`ifndef INTEGER_STRING_PARSER_DEFINES_SVH
`define INTEGER_STRING_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ISP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ISP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/isp_pkg.sv @@
// types, constants and helper functions for the integer string parser
`timescale 1ns / 1ps

package isp_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;
    localparam int BASE_WIDTH   = 6;
    localparam int DIGIT_WIDTH  = 6;
    localparam int CHAR_WIDTH   = 8;

    // marks a byte that is no digit at all; above every real digit value
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = '1;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET = 8'd10;

    localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

    typedef enum logic
    {
        REG_NUMBER_BASE = 1'b0,
        REG_SIGNED_MODE = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed
    {
        logic [VALUE_WIDTH-1:0]  parsed_value;
        logic [OFFSET_WIDTH-1:0] end_offset;
    } result_t;

    function automatic logic [DIGIT_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] b);
        logic [DIGIT_WIDTH-1:0] d;
        d = DIGIT_NONE;
        if (b inside {[CH_ZERO:CH_NINE]})
        begin
            d = DIGIT_WIDTH'(b - CH_ZERO);
        end
        else if (b inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            d = DIGIT_WIDTH'(b - CH_LOWER_A + LETTER_OFFSET);
        end
        else if (b inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            d = DIGIT_WIDTH'(b - CH_UPPER_A + LETTER_OFFSET);
        end
        return d;
    endfunction

    // count plus one or two, holding at all ones
    function automatic logic [OFFSET_WIDTH-1:0] sat_add(input logic [OFFSET_WIDTH-1:0] cnt,
                                                        input logic [1:0] n);
        logic [OFFSET_WIDTH:0] s;
        s = {1'b0, cnt} + (OFFSET_WIDTH + 1)'(n);
        return s[OFFSET_WIDTH] ? {OFFSET_WIDTH{1'b1}} : s[OFFSET_WIDTH-1:0];
    endfunction

endpackage

@@ hdl/isp_if.sv @@
// valid/ready channel interfaces for characters in and results out
`timescale 1ns / 1ps

interface isp_char_if;
    logic                            valid;
    logic                            ready;
    logic [isp_pkg::CHAR_WIDTH-1:0]  char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface isp_result_if;
    logic                             valid;
    logic                             ready;
    logic [isp_pkg::VALUE_WIDTH-1:0]  parsed_value;
    logic [isp_pkg::OFFSET_WIDTH-1:0] end_offset;

    modport source (output valid, output parsed_value, output end_offset, input ready);
    modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

@@ hdl/integer_string_parser.sv @@
// integer string parser: one character a cycle in, one result per zero-terminated string
// a terminator is registered in the input stage, and its result in the output register
// throughput: one character per cycle; the only stall is a terminator meeting a held result
// the single multiply-add of accumulator by base sits between input and state registers
// reset clears the parse state and both handshakes; number_base resets to 0, signed_mode to 1
`timescale 1ns / 1ps

module integer_string_parser
(
    input  logic                           clk,
    input  logic                           rst_n,
    isp_char_if.sink                       char_in,
    isp_result_if.source                   result_out,
    input  logic                           wr_en,
    input  logic                           wr_index,
    input  logic [isp_pkg::BASE_WIDTH-1:0] wr_data
);

    logic [isp_pkg::BASE_WIDTH-1:0] number_base_reg;
    logic                           signed_mode_reg;
    logic                           byte_valid;
    logic [isp_pkg::CHAR_WIDTH-1:0] byte_data;
    logic                           advance;
    logic                           res_valid;
    isp_pkg::result_t               res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= isp_pkg::BASE_AUTO;
            signed_mode_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                isp_pkg::REG_NUMBER_BASE: number_base_reg <= wr_data;
                isp_pkg::REG_SIGNED_MODE: signed_mode_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // a terminator waits while the previous result is still held
    assign advance = byte_valid &&
                     !(byte_data == isp_pkg::CH_NUL && result_out.valid && !result_out.ready);

    isp_char_stage u_char_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    isp_parse_core u_parse_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .byte_data   (byte_data),
        .number_base (number_base_reg),
        .signed_mode (signed_mode_reg),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    isp_result_reg u_result_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .load_data  (res_data),
        .result_out (result_out)
    );

endmodule

@@ hdl/isp_char_stage.sv @@
// input register holding one character between the channel and the parse logic
`timescale 1ns / 1ps

module isp_char_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    isp_char_if.sink                       char_in,
    input  logic                           advance,
    output logic                           byte_valid,
    output logic [isp_pkg::CHAR_WIDTH-1:0] byte_data
);

    logic                           valid_reg;
    logic [isp_pkg::CHAR_WIDTH-1:0] data_reg;
    logic                           load;

    assign char_in.ready = !valid_reg || advance;
    assign load          = char_in.valid && char_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= char_in.char_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

@@ hdl/isp_parse_core.sv @@
// parse state and the per-character update: whitespace, sign, prefix, digits
`timescale 1ns / 1ps

module isp_parse_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [isp_pkg::CHAR_WIDTH-1:0] byte_data,
    input  logic [isp_pkg::BASE_WIDTH-1:0] number_base,
    input  logic                           signed_mode,
    output logic                           res_valid,
    output isp_pkg::result_t               res_data
);

    isp_pkg::phase_t                  phase_reg, phase_next;
    logic [isp_pkg::BASE_WIDTH-1:0]   base_reg, base_next;
    logic                             neg_reg, neg_next;
    logic [isp_pkg::VALUE_WIDTH-1:0]  acc_reg, acc_next;
    logic [isp_pkg::OFFSET_WIDTH-1:0] cnt_reg, cnt_next;

    isp_pkg::phase_t                  work_phase;
    logic [isp_pkg::OFFSET_WIDTH-1:0] work_cnt;
    logic                             prefix_x;
    logic                             start;
    logic                             take;
    logic [isp_pkg::BASE_WIDTH-1:0]   take_base;
    logic [isp_pkg::DIGIT_WIDTH-1:0]  digit;
    logic [isp_pkg::VALUE_WIDTH-1:0]  product;

    assign digit   = isp_pkg::digit_value(byte_data);
    assign product = acc_reg * isp_pkg::VALUE_WIDTH'(take_base);

    // base used by the digit path: picked at the first byte after whitespace and any sign
    always_comb
    begin
        take_base = base_reg;
        if (phase_reg == isp_pkg::PH_SPACE || phase_reg == isp_pkg::PH_SIGNED)
        begin
            take_base = (number_base == isp_pkg::BASE_AUTO) ? isp_pkg::BASE_DEC : number_base;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        work_phase = phase_reg;
        work_cnt   = cnt_reg;
        prefix_x   = 1'b0;
        start      = 1'b0;
        take       = 1'b0;
        res_valid  = 1'b0;
        res_data.parsed_value = neg_reg ? (isp_pkg::VALUE_WIDTH'(0) - acc_reg) : acc_reg;
        res_data.end_offset   = cnt_reg;

        if (step)
        begin
            // a pending leading zero resolves into a hex prefix or an ordinary digit
            if (phase_reg == isp_pkg::PH_ZERO)
            begin
                if (byte_data == isp_pkg::CH_LOWER_X || byte_data == isp_pkg::CH_UPPER_X)
                begin
                    prefix_x   = 1'b1;
                    cnt_next   = isp_pkg::sat_add(cnt_reg, 2'd2);
                    base_next  = isp_pkg::BASE_HEX;
                    phase_next = isp_pkg::PH_DIGITS;
                end
                else
                begin
                    work_cnt   = isp_pkg::sat_add(cnt_reg, 2'd1);
                    work_phase = isp_pkg::PH_DIGITS;
                    cnt_next   = work_cnt;
                    phase_next = isp_pkg::PH_DIGITS;
                end
            end

            if (!prefix_x)
            begin
                if (byte_data == isp_pkg::CH_NUL)
                begin
                    res_valid           = 1'b1;
                    res_data.end_offset = work_cnt;
                    phase_next          = isp_pkg::PH_SPACE;
                    base_next           = '0;
                    neg_next            = 1'b0;
                    acc_next            = '0;
                    cnt_next            = '0;
                end
                else
                begin
                    case (work_phase)
                        isp_pkg::PH_SPACE:
                        begin
                            if (byte_data inside {isp_pkg::CH_SPACE, isp_pkg::CH_TAB,
                                                  isp_pkg::CH_LF, isp_pkg::CH_CR})
                            begin
                                cnt_next = isp_pkg::sat_add(work_cnt, 2'd1);
                            end
                            else if (byte_data == isp_pkg::CH_MINUS && signed_mode)
                            begin
                                neg_next   = 1'b1;
                                cnt_next   = isp_pkg::sat_add(work_cnt, 2'd1);
                                phase_next = isp_pkg::PH_SIGNED;
                            end
                            else if (byte_data == isp_pkg::CH_PLUS)
                            begin
                                cnt_next   = isp_pkg::sat_add(work_cnt, 2'd1);
                                phase_next = isp_pkg::PH_SIGNED;
                            end
                            else
                            begin
                                start = 1'b1;
                            end
                        end
                        isp_pkg::PH_SIGNED:
                        begin
                            start = 1'b1;
                        end
                        isp_pkg::PH_DIGITS:
                        begin
                            take = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (start)
                    begin
                        if (number_base == isp_pkg::BASE_AUTO)
                        begin
                            if (byte_data == isp_pkg::CH_ZERO)
                            begin
                                base_next  = isp_pkg::BASE_OCT;
                                phase_next = isp_pkg::PH_ZERO;
                            end
                            else
                            begin
                                base_next = isp_pkg::BASE_DEC;
                                take      = 1'b1;
                            end
                        end
                        else
                        begin
                            base_next = number_base;
                            if (number_base == isp_pkg::BASE_HEX && byte_data == isp_pkg::CH_ZERO)
                            begin
                                phase_next = isp_pkg::PH_ZERO;
                            end
                            else
                            begin
                                take = 1'b1;
                            end
                        end
                    end

                    if (take)
                    begin
                        if (digit < take_base)
                        begin
                            acc_next   = product + isp_pkg::VALUE_WIDTH'(digit);
                            cnt_next   = isp_pkg::sat_add(work_cnt, 2'd1);
                            phase_next = isp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = isp_pkg::PH_DONE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= isp_pkg::PH_SPACE;
            base_reg  <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/isp_result_reg.sv @@
// output register for finished results, held until the sink takes the transfer
`timescale 1ns / 1ps

module isp_result_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  isp_pkg::result_t load_data,
    isp_result_if.source     result_out
);

    logic             valid_reg;
    isp_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_out.valid        = valid_reg;
    assign result_out.parsed_value = data_reg.parsed_value;
    assign result_out.end_offset   = data_reg.end_offset;

endmodule

@@ hdl/isp_checker.sv @@
// port-level checks for the integer string parser, bound to the top level
`timescale 1ns / 1ps
`include "integer_string_parser_defines.svh"

module isp_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [isp_pkg::CHAR_WIDTH-1:0]   in_byte,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [isp_pkg::VALUE_WIDTH-1:0]  out_value,
    input logic [isp_pkg::OFFSET_WIDTH-1:0] out_offset
);

    // a held result keeps its payload
    `ISP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_offset), "result changed while stalled")

    // a new result only follows a terminator transfer
    `ISP_ASSERT_SAME(a_result_from_nul, $rose(out_valid), $past(in_valid && in_ready && in_byte == isp_pkg::CH_NUL, 2), "result without terminator")

    // input back-pressure only comes from a stalled result
    `ISP_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without cause")

endmodule

bind integer_string_parser isp_checker u_isp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (char_in.valid),
    .in_ready   (char_in.ready),
    .in_byte    (char_in.char_byte),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_value  (result_out.parsed_value),
    .out_offset (result_out.end_offset)
);
